// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// condition holds at every clock edge
`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, cond)
`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hw/rtl/bcdc_pkg.sv =====
// ----------------------------------------------------------------------------
// bcdc_pkg
// shared types, command codes, reset values and battery-type table
// ----------------------------------------------------------------------------
package bcdc_pkg;

    // controller states
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHG   = 5'b00010,
        ST_DIS   = 5'b00100,
        ST_CDONE = 5'b01000,
        ST_DDONE = 5'b10000
    } state_t;

    // mode codes as seen on the result channel
    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_CHG   = 3'd1;
    localparam logic [2:0] MODE_DIS   = 3'd2;
    localparam logic [2:0] MODE_CDONE = 3'd3;
    localparam logic [2:0] MODE_DDONE = 3'd4;

    // command addresses
    localparam logic [15:0] ADDR_CTRL   = 16'h0000;
    localparam logic [15:0] ADDR_OVER   = 16'h0010;
    localparam logic [15:0] ADDR_UNDER  = 16'h0011;
    localparam logic [15:0] ADDR_SELECT = 16'h0013;
    localparam logic [15:0] ADDR_KIND   = 16'h0015;

    // control values at the control address
    localparam logic [15:0] CTRL_START_DIS = 16'd1;
    localparam logic [15:0] CTRL_STOP_DIS  = 16'd2;
    localparam logic [15:0] CTRL_START_CHG = 16'd3;
    localparam logic [15:0] CTRL_STOP_CHG  = 16'd4;
    localparam logic [15:0] CTRL_STOP_BOTH = 16'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_MIN_CURRENT     = 2'd0;
    localparam logic [1:0] CFG_START_BLANK     = 2'd1;
    localparam logic [1:0] CFG_PROTECT_CONFIRM = 2'd2;
    localparam logic [1:0] CFG_DONE_CONFIRM    = 2'd3;

    // reset values
    localparam logic [15:0] RST_MIN_CURRENT     = 16'd300;
    localparam logic [31:0] RST_START_BLANK     = 32'd50000;
    localparam logic [31:0] RST_PROTECT_CONFIRM = 32'd50000;
    localparam logic [31:0] RST_DONE_CONFIRM    = 32'd30000;
    localparam logic [15:0] RST_OVER_LIMIT      = 16'd21000;
    localparam logic [15:0] RST_UNDER_LIMIT     = 16'd16000;

    typedef struct packed {
        logic [15:0] min_current_ma;
        logic [31:0] start_blank_ms;
        logic [31:0] protect_confirm_ms;
        logic [31:0] done_confirm_ms;
    } cfg_t;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [15:0] bat_volt_mv;
        logic [15:0] charge_ma;
        logic [15:0] discharge_ma;
        logic        has_command;
        logic [15:0] cmd_addr;
        logic [15:0] cmd_value;
    } item_t;

    typedef struct packed {
        logic        charge_on;
        logic        discharge_on;
        logic        fan_on;
        logic        charge_led;
        logic        discharge_led;
        logic [2:0]  mode;
        logic [1:0]  volt_select;
        logic [15:0] over_limit_mv;
        logic [15:0] under_limit_mv;
        logic [7:0]  battery_kind;
    } res_t;

    typedef struct packed {
        logic stop_dis;
        logic stop_chg;
        logic start_chg;
        logic start_dis;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [1:0]  select;
        logic [15:0] over;
        logic [15:0] under;
    } kind_entry_t;

    // battery-type table, codes above 2 have no entry
    function automatic kind_entry_t kind_lookup(input logic [7:0] kind);
        kind_entry_t e;
        e = '0;
        case (kind)
            8'd0:
            begin
                e.hit    = 1'b1;
                e.select = 2'd0;
                e.over   = 16'd21500;
                e.under  = 16'd12000;
            end
            8'd1:
            begin
                e.hit    = 1'b1;
                e.select = 2'd3;
                e.over   = 16'd17500;
                e.under  = 16'd10000;
            end
            8'd2:
            begin
                e.hit    = 1'b1;
                e.select = 2'd3;
                e.over   = 16'd15000;
                e.under  = 16'd8500;
            end
            default:
            begin
                e.hit = 1'b0;
            end
        endcase
        return e;
    endfunction

    function automatic logic [2:0] mode_code(input state_t s);
        logic [2:0] m;
        case (s)
            ST_IDLE:  m = MODE_IDLE;
            ST_CHG:   m = MODE_CHG;
            ST_DIS:   m = MODE_DIS;
            ST_CDONE: m = MODE_CDONE;
            ST_DDONE: m = MODE_DDONE;
            default:  m = MODE_IDLE;
        endcase
        return m;
    endfunction

endpackage

// ===== hw/rtl/bcdc_channels.sv =====
// ----------------------------------------------------------------------------
// bcdc_channels
// valid/ready channels for measurement items and controller results
// ----------------------------------------------------------------------------
interface bcdc_item_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic [15:0] bat_volt_mv;
    logic [15:0] charge_ma;
    logic [15:0] discharge_ma;
    logic        has_command;
    logic [15:0] cmd_addr;
    logic [15:0] cmd_value;

    modport source (
        output valid, now_ms, bat_volt_mv, charge_ma, discharge_ma,
               has_command, cmd_addr, cmd_value,
        input  ready
    );

    modport sink (
        input  valid, now_ms, bat_volt_mv, charge_ma, discharge_ma,
               has_command, cmd_addr, cmd_value,
        output ready
    );
endinterface

interface bcdc_result_if;
    logic        valid;
    logic        ready;
    logic        charge_on;
    logic        discharge_on;
    logic        fan_on;
    logic        charge_led;
    logic        discharge_led;
    logic [2:0]  mode;
    logic [1:0]  volt_select;
    logic [15:0] over_limit_mv;
    logic [15:0] under_limit_mv;
    logic [7:0]  battery_kind;

    modport source (
        output valid, charge_on, discharge_on, fan_on, charge_led, discharge_led,
               mode, volt_select, over_limit_mv, under_limit_mv, battery_kind,
        input  ready
    );

    modport sink (
        input  valid, charge_on, discharge_on, fan_on, charge_led, discharge_led,
               mode, volt_select, over_limit_mv, under_limit_mv, battery_kind,
        output ready
    );
endinterface

// ===== hw/rtl/battery_charge_discharge_controller.sv =====
// ----------------------------------------------------------------------------
// battery_charge_discharge_controller
// path: input register, then core state registers, then the result beat
// throughput: one item per cycle unless a result beat stalls the state update
// a stalled result beat holds the core, and item ready once the input reg is full
// reset: idle, all outputs off, limits 21000/16000 mV, registers at defaults
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module battery_charge_discharge_controller (
    input  logic        clk,
    input  logic        rst_n,
    bcdc_item_if.sink   item,
    bcdc_result_if.source result,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [31:0] wr_data
);
    import bcdc_pkg::*;

    cfg_t  cfg_reg;
    item_t item_reg;
    logic  in_valid_reg;
    logic  out_valid_reg;
    logic  advance;
    logic  step;
    res_t  res;

    // the state registers double as the result register
    assign advance    = !out_valid_reg || result.ready;
    assign step       = in_valid_reg && advance;
    assign item.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_current_ma     <= RST_MIN_CURRENT;
            cfg_reg.start_blank_ms     <= RST_START_BLANK;
            cfg_reg.protect_confirm_ms <= RST_PROTECT_CONFIRM;
            cfg_reg.done_confirm_ms    <= RST_DONE_CONFIRM;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_MIN_CURRENT:     cfg_reg.min_current_ma     <= wr_data[15:0];
                CFG_START_BLANK:     cfg_reg.start_blank_ms     <= wr_data;
                CFG_PROTECT_CONFIRM: cfg_reg.protect_confirm_ms <= wr_data;
                CFG_DONE_CONFIRM:    cfg_reg.done_confirm_ms    <= wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item.valid && item.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                in_valid_reg <= 1'b0;
            end

            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            item_reg.now_ms       <= item.now_ms;
            item_reg.bat_volt_mv  <= item.bat_volt_mv;
            item_reg.charge_ma    <= item.charge_ma;
            item_reg.discharge_ma <= item.discharge_ma;
            item_reg.has_command  <= item.has_command;
            item_reg.cmd_addr     <= item.cmd_addr;
            item_reg.cmd_value    <= item.cmd_value;
        end
    end

    bcdc_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item_reg),
        .cfg   (cfg_reg),
        .res   (res)
    );

    assign result.valid          = out_valid_reg;
    assign result.charge_on      = res.charge_on;
    assign result.discharge_on   = res.discharge_on;
    assign result.fan_on         = res.fan_on;
    assign result.charge_led     = res.charge_led;
    assign result.discharge_led  = res.discharge_led;
    assign result.mode           = res.mode;
    assign result.volt_select    = res.volt_select;
    assign result.over_limit_mv  = res.over_limit_mv;
    assign result.under_limit_mv = res.under_limit_mv;
    assign result.battery_kind   = res.battery_kind;

    `ASSERT_ALWAYS(a_no_dual_path, !(res.charge_on && res.discharge_on))
    `ASSERT_ALWAYS(a_fan_follows_dis, res.fan_on == res.discharge_on)
    `ASSERT_IMPLIES(a_chg_mode_drive, res.mode == MODE_CHG, res.charge_on && res.charge_led)
    `ASSERT_IMPLIES(a_done_paths_off, res.mode >= MODE_CDONE, !res.charge_on && !res.discharge_on)
    `ASSERT_NEXT(a_item_moves, in_valid_reg && !out_valid_reg, out_valid_reg)

endmodule

// ===== hw/rtl/bcdc_confirm.sv =====
// ----------------------------------------------------------------------------
// bcdc_confirm
// one confirm timer: a condition must persist for a given time before firing
// ----------------------------------------------------------------------------
module bcdc_confirm (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        cond,
    input  logic [31:0] now_ms,
    input  logic [31:0] need_ms,
    output logic        fire
);
    logic        flag_reg;
    logic        flag_next;
    logic [31:0] begin_reg;
    logic [31:0] begin_next;
    logic [31:0] elapsed;

    // modulo 2^32 difference, safe across a timestamp wrap
    assign elapsed = now_ms - begin_reg;
    assign fire    = cond && flag_reg && (elapsed >= need_ms);

    always_comb
    begin
        flag_next  = flag_reg;
        begin_next = begin_reg;
        if (en)
        begin
            if (!cond)
            begin
                flag_next = 1'b0;
            end
            else if (!flag_reg)
            begin
                flag_next  = 1'b1;
                begin_next = now_ms;
            end
            else if (fire)
            begin
                flag_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
        end
        else
        begin
            flag_reg <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        begin_reg <= begin_next;
    end

endmodule

// ===== hw/rtl/bcdc_core.sv =====
// ----------------------------------------------------------------------------
// bcdc_core
// command decode, request handling and the five-state controller
// ----------------------------------------------------------------------------
module bcdc_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  bcdc_pkg::item_t item,
    input  bcdc_pkg::cfg_t  cfg,
    output bcdc_pkg::res_t  res
);
    import bcdc_pkg::*;

    state_t      state_reg, state_next;
    logic [15:0] over_reg, over_next;
    logic [15:0] under_reg, under_next;
    logic [7:0]  kind_reg, kind_next;
    logic [1:0]  select_reg, select_next;
    logic [31:0] chg_begin_reg, chg_begin_next;
    logic [31:0] dis_begin_reg, dis_begin_next;
    logic        chg_on_reg, chg_on_next;
    logic        dis_on_reg, dis_on_next;
    logic        fan_reg, fan_next;
    logic        cled_reg, cled_next;
    logic        dled_reg, dled_next;

    req_t        req;
    kind_entry_t kind_entry;
    state_t      req_state;
    logic [31:0] chg_elapsed;
    logic [31:0] dis_elapsed;
    logic        chg_run;
    logic        dis_run;
    logic        cond_over, cond_under, cond_cdone, cond_ddone;
    logic        fire_over, fire_under, fire_cdone, fire_ddone;

    // command decode and settings writes
    always_comb
    begin
        req         = '0;
        over_next   = over_reg;
        under_next  = under_reg;
        kind_next   = kind_reg;
        select_next = select_reg;
        kind_entry  = kind_lookup(kind_reg);
        if (item.has_command)
        begin
            case (item.cmd_addr)
                ADDR_CTRL:
                begin
                    case (item.cmd_value)
                        CTRL_START_DIS: req.start_dis = 1'b1;
                        CTRL_STOP_DIS:  req.stop_dis  = 1'b1;
                        CTRL_START_CHG: req.start_chg = 1'b1;
                        CTRL_STOP_CHG:  req.stop_chg  = 1'b1;
                        CTRL_STOP_BOTH:
                        begin
                            req.stop_chg = 1'b1;
                            req.stop_dis = 1'b1;
                        end
                        default: ;
                    endcase
                end
                ADDR_OVER:   over_next   = item.cmd_value;
                ADDR_UNDER:  under_next  = item.cmd_value;
                ADDR_SELECT: select_next = item.cmd_value[1:0];
                ADDR_KIND:
                begin
                    kind_next  = item.cmd_value[7:0];
                    kind_entry = kind_lookup(item.cmd_value[7:0]);
                    if (kind_entry.hit)
                    begin
                        select_next = kind_entry.select;
                        over_next   = kind_entry.over;
                        under_next  = kind_entry.under;
                    end
                end
                default: ;
            endcase
        end

        // requests in fixed order: stop dis, stop chg, start chg, start dis
        req_state      = state_reg;
        chg_on_next    = chg_on_reg;
        dis_on_next    = dis_on_reg;
        fan_next       = fan_reg;
        chg_begin_next = chg_begin_reg;
        dis_begin_next = dis_begin_reg;
        if (req.stop_dis && (req_state == ST_DIS || req_state == ST_DDONE))
        begin
            dis_on_next = 1'b0;
            fan_next    = 1'b0;
            req_state   = ST_IDLE;
        end
        if (req.stop_chg && (req_state == ST_CHG || req_state == ST_CDONE))
        begin
            chg_on_next = 1'b0;
            req_state   = ST_IDLE;
        end
        if (req.start_chg && req_state == ST_IDLE)
        begin
            if (kind_entry.hit)
            begin
                select_next = kind_entry.select;
                over_next   = kind_entry.over;
                under_next  = kind_entry.under;
            end
            chg_on_next    = 1'b1;
            req_state      = ST_CHG;
            chg_begin_next = item.now_ms;
        end
        if (req.start_dis && req_state == ST_IDLE)
        begin
            dis_on_next    = 1'b1;
            fan_next       = 1'b1;
            req_state      = ST_DIS;
            dis_begin_next = item.now_ms;
        end
    end

    // checks start after the blanking time
    assign chg_elapsed = item.now_ms - chg_begin_next;
    assign dis_elapsed = item.now_ms - dis_begin_next;
    assign chg_run     = (req_state == ST_CHG) && (chg_elapsed >= cfg.start_blank_ms);
    assign dis_run     = (req_state == ST_DIS) && (dis_elapsed >= cfg.start_blank_ms);

    assign cond_over  = (item.bat_volt_mv >= over_next) &&
                        (item.charge_ma > cfg.min_current_ma);
    assign cond_cdone = item.charge_ma <= cfg.min_current_ma;
    assign cond_under = (item.bat_volt_mv <= under_next) &&
                        (item.discharge_ma > cfg.min_current_ma);
    assign cond_ddone = item.discharge_ma <= cfg.min_current_ma;

    bcdc_confirm u_over (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (step && chg_run),
        .cond    (cond_over),
        .now_ms  (item.now_ms),
        .need_ms (cfg.protect_confirm_ms),
        .fire    (fire_over)
    );

    bcdc_confirm u_under (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (step && dis_run),
        .cond    (cond_under),
        .now_ms  (item.now_ms),
        .need_ms (cfg.protect_confirm_ms),
        .fire    (fire_under)
    );

    bcdc_confirm u_cdone (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (step && chg_run),
        .cond    (cond_cdone),
        .now_ms  (item.now_ms),
        .need_ms (cfg.done_confirm_ms),
        .fire    (fire_cdone)
    );

    bcdc_confirm u_ddone (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (step && dis_run),
        .cond    (cond_ddone),
        .now_ms  (item.now_ms),
        .need_ms (cfg.done_confirm_ms),
        .fire    (fire_ddone)
    );

    // controller
    always_comb
    begin
        state_next = req_state;
        cled_next  = cled_reg;
        dled_next  = dled_reg;
        case (req_state)
            ST_IDLE:
            begin
                cled_next = 1'b0;
                dled_next = 1'b0;
            end
            ST_CHG:
            begin
                cled_next = 1'b1;
                dled_next = 1'b0;
                if (chg_run)
                begin
                    // done confirm wins when both fire together
                    if (fire_cdone)
                    begin
                        state_next = ST_CDONE;
                    end
                    else if (fire_over)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DIS:
            begin
                dled_next = 1'b1;
                cled_next = 1'b0;
                if (dis_run)
                begin
                    if (fire_ddone)
                    begin
                        state_next = ST_DDONE;
                    end
                    else if (fire_under)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                // done states fall back to idle, leds hold
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            over_reg      <= RST_OVER_LIMIT;
            under_reg     <= RST_UNDER_LIMIT;
            kind_reg      <= '0;
            select_reg    <= '0;
            chg_begin_reg <= '0;
            dis_begin_reg <= '0;
            chg_on_reg    <= 1'b0;
            dis_on_reg    <= 1'b0;
            fan_reg       <= 1'b0;
            cled_reg      <= 1'b0;
            dled_reg      <= 1'b0;
        end
        else if (step)
        begin
            state_reg     <= state_next;
            over_reg      <= over_next;
            under_reg     <= under_next;
            kind_reg      <= kind_next;
            select_reg    <= select_next;
            chg_begin_reg <= chg_begin_next;
            dis_begin_reg <= dis_begin_next;
            chg_on_reg    <= chg_on_next && !(chg_run && (fire_cdone || fire_over));
            dis_on_reg    <= dis_on_next && !(dis_run && (fire_ddone || fire_under));
            fan_reg       <= fan_next && !(dis_run && (fire_ddone || fire_under));
            cled_reg      <= cled_next;
            dled_reg      <= dled_next;
        end
    end

    always_comb
    begin
        res.charge_on      = chg_on_reg;
        res.discharge_on   = dis_on_reg;
        res.fan_on         = fan_reg;
        res.charge_led     = cled_reg;
        res.discharge_led  = dled_reg;
        res.mode           = mode_code(state_reg);
        res.volt_select    = select_reg;
        res.over_limit_mv  = over_reg;
        res.under_limit_mv = under_reg;
        res.battery_kind   = kind_reg;
    end

endmodule

// ===== dv/tb_battery_charge_discharge_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_battery_charge_discharge_controller
// Drives measurement items with optional commands into the controller and
// checks every result beat against a cycle-free model of the charge and
// discharge state machine. A short table of hand-picked steps comes first,
// then random charge and discharge sessions under several timing settings,
// with random gaps on the item side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_battery_charge_discharge_controller;
    import bcdc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    // wait slots of the cut-off and completion checks
    localparam logic [1:0] SLOT_OVER  = 2'd0;
    localparam logic [1:0] SLOT_UNDER = 2'd1;
    localparam logic [1:0] SLOT_CDONE = 2'd2;
    localparam logic [1:0] SLOT_DDONE = 2'd3;

    // battery types that have a table entry
    localparam logic [7:0] KIND_TYPE0 = 8'd0;
    localparam logic [7:0] KIND_TYPE1 = 8'd1;
    localparam logic [7:0] KIND_TYPE2 = 8'd2;

    typedef struct packed {
        item_t stim;
        logic  fixed;
        res_t  want;
    } bringup_step_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        wr_en;
    logic [1:0]  wr_index;
    logic [31:0] wr_data;
    logic        take_ready = 1'b0;

    bcdc_item_if   item_ch();
    bcdc_result_if res_ch();

    assign res_ch.ready = take_ready;

    battery_charge_discharge_controller u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_ch),
        .result   (res_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #10 clk = ~clk;

    // controller model state
    cfg_t        ctl_cfg;
    logic [2:0]  ctl_mode;
    logic [15:0] ctl_over;
    logic [15:0] ctl_under;
    logic [7:0]  ctl_kind;
    logic [1:0]  ctl_sel;
    logic [31:0] ctl_chg_t0;
    logic [31:0] ctl_dis_t0;
    logic [3:0]  ctl_wait;
    logic [31:0] ctl_since [4];
    logic        ctl_chg_on;
    logic        ctl_dis_on;
    logic        ctl_fan;
    logic        ctl_cled;
    logic        ctl_dled;

    res_t          due_outputs [$];
    bringup_step_t bringup_steps [$];
    int            n_mismatch = 0;
    int            n_items = 0;
    int unsigned   n_cycles = 0;
    int            stall_left = 0;
    bit            calm = 1'b0;
    logic [31:0]   clock_ms = 32'd0;

    function automatic void load_kind_limits();
        case (ctl_kind)
            KIND_TYPE0:
            begin
                ctl_sel   = 2'd0;
                ctl_over  = 16'd21500;
                ctl_under = 16'd12000;
            end
            KIND_TYPE1:
            begin
                ctl_sel   = 2'd3;
                ctl_over  = 16'd17500;
                ctl_under = 16'd10000;
            end
            KIND_TYPE2:
            begin
                ctl_sel   = 2'd3;
                ctl_over  = 16'd15000;
                ctl_under = 16'd8500;
            end
            default:
            begin
            end
        endcase
    endfunction

    // true once the condition has held for need ms since it was first seen
    function automatic bit hold_met(input logic [1:0] slot, input bit cond,
                                    input logic [31:0] t, input logic [31:0] need);
        if (!cond)
        begin
            ctl_wait[slot] = 1'b0;
            return 1'b0;
        end
        if (!ctl_wait[slot])
        begin
            ctl_wait[slot]  = 1'b1;
            ctl_since[slot] = t;
            return 1'b0;
        end
        if (t - ctl_since[slot] >= need)
        begin
            ctl_wait[slot] = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic res_t advance_controller(input item_t it);
        res_t r;
        bit   go_dis;
        bit   halt_dis;
        bit   go_chg;
        bit   halt_chg;
        go_dis   = 1'b0;
        halt_dis = 1'b0;
        go_chg   = 1'b0;
        halt_chg = 1'b0;
        if (it.has_command)
        begin
            case (it.cmd_addr)
                ADDR_CTRL:
                begin
                    case (it.cmd_value)
                        CTRL_START_DIS: go_dis = 1'b1;
                        CTRL_STOP_DIS:  halt_dis = 1'b1;
                        CTRL_START_CHG: go_chg = 1'b1;
                        CTRL_STOP_CHG:  halt_chg = 1'b1;
                        CTRL_STOP_BOTH:
                        begin
                            halt_chg = 1'b1;
                            halt_dis = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ADDR_OVER:   ctl_over = it.cmd_value;
                ADDR_UNDER:  ctl_under = it.cmd_value;
                ADDR_SELECT: ctl_sel = it.cmd_value[1:0];
                ADDR_KIND:
                begin
                    ctl_kind = it.cmd_value[7:0];
                    load_kind_limits();
                end
                default:
                begin
                end
            endcase
        end

        // requests in fixed order, each only from its own states
        if (halt_dis && (ctl_mode == MODE_DIS || ctl_mode == MODE_DDONE))
        begin
            ctl_dis_on = 1'b0;
            ctl_fan    = 1'b0;
            ctl_mode   = MODE_IDLE;
        end
        if (halt_chg && (ctl_mode == MODE_CHG || ctl_mode == MODE_CDONE))
        begin
            ctl_chg_on = 1'b0;
            ctl_mode   = MODE_IDLE;
        end
        if (go_chg && ctl_mode == MODE_IDLE)
        begin
            load_kind_limits();
            ctl_chg_on = 1'b1;
            ctl_mode   = MODE_CHG;
            ctl_chg_t0 = it.now_ms;
        end
        if (go_dis && ctl_mode == MODE_IDLE)
        begin
            ctl_dis_on = 1'b1;
            ctl_fan    = 1'b1;
            ctl_mode   = MODE_DIS;
            ctl_dis_t0 = it.now_ms;
        end

        case (ctl_mode)
            MODE_IDLE:
            begin
                ctl_cled = 1'b0;
                ctl_dled = 1'b0;
            end
            MODE_CHG:
            begin
                ctl_cled = 1'b1;
                ctl_dled = 1'b0;
                if (it.now_ms - ctl_chg_t0 >= ctl_cfg.start_blank_ms)
                begin
                    if (hold_met(SLOT_OVER,
                                 it.bat_volt_mv >= ctl_over &&
                                 it.charge_ma > ctl_cfg.min_current_ma,
                                 it.now_ms, ctl_cfg.protect_confirm_ms))
                    begin
                        ctl_chg_on = 1'b0;
                        ctl_mode   = MODE_IDLE;
                    end
                    if (hold_met(SLOT_CDONE, it.charge_ma <= ctl_cfg.min_current_ma,
                                 it.now_ms, ctl_cfg.done_confirm_ms))
                    begin
                        ctl_chg_on = 1'b0;
                        ctl_mode   = MODE_CDONE;
                    end
                end
            end
            MODE_DIS:
            begin
                ctl_dled = 1'b1;
                ctl_cled = 1'b0;
                if (it.now_ms - ctl_dis_t0 >= ctl_cfg.start_blank_ms)
                begin
                    if (hold_met(SLOT_UNDER,
                                 it.bat_volt_mv <= ctl_under &&
                                 it.discharge_ma > ctl_cfg.min_current_ma,
                                 it.now_ms, ctl_cfg.protect_confirm_ms))
                    begin
                        ctl_dis_on = 1'b0;
                        ctl_fan    = 1'b0;
                        ctl_mode   = MODE_IDLE;
                    end
                    if (hold_met(SLOT_DDONE, it.discharge_ma <= ctl_cfg.min_current_ma,
                                 it.now_ms, ctl_cfg.done_confirm_ms))
                    begin
                        ctl_dis_on = 1'b0;
                        ctl_fan    = 1'b0;
                        ctl_mode   = MODE_DDONE;
                    end
                end
            end
            // done states fall back to idle, leds untouched
            default:
            begin
                ctl_mode = MODE_IDLE;
            end
        endcase

        r.charge_on      = ctl_chg_on;
        r.discharge_on   = ctl_dis_on;
        r.fan_on         = ctl_fan;
        r.charge_led     = ctl_cled;
        r.discharge_led  = ctl_dled;
        r.mode           = ctl_mode;
        r.volt_select    = ctl_sel;
        r.over_limit_mv  = ctl_over;
        r.under_limit_mv = ctl_under;
        r.battery_kind   = ctl_kind;
        return r;
    endfunction

    function automatic res_t idle_view(input logic [1:0] sel, input logic [15:0] over,
                                       input logic [15:0] under, input logic [7:0] kind);
        res_t r;
        r                = '0;
        r.mode           = MODE_IDLE;
        r.volt_select    = sel;
        r.over_limit_mv  = over;
        r.under_limit_mv = under;
        r.battery_kind   = kind;
        return r;
    endfunction

    function automatic item_t mk_item(input logic [31:0] t, input logic [15:0] volt,
                                      input logic [15:0] cma, input logic [15:0] dma,
                                      input logic has, input logic [15:0] addr,
                                      input logic [15:0] val);
        item_t it;
        it.now_ms       = t;
        it.bat_volt_mv  = volt;
        it.charge_ma    = cma;
        it.discharge_ma = dma;
        it.has_command  = has;
        it.cmd_addr     = addr;
        it.cmd_value    = val;
        return it;
    endfunction

    function automatic string fmt_res(input res_t r);
        return $sformatf(
            "chg=%b dis=%b fan=%b cled=%b dled=%b mode=%0d sel=%0d over=%0d under=%0d kind=%0d",
            r.charge_on, r.discharge_on, r.fan_on, r.charge_led,
            r.discharge_led, r.mode, r.volt_select, r.over_limit_mv,
            r.under_limit_mv, r.battery_kind);
    endfunction

    // mostly short gaps, now and then a long one, none in a calm stretch
    function automatic int gap_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    // measurement at the running clock, voltage and currents per regime
    function automatic item_t meas_item(input int vpick, input bit clow, input bit dlow);
        item_t it;
        it.now_ms = clock_ms;
        case (vpick)
            0:       it.bat_volt_mv = 16'($urandom_range(16'hFFFF, ctl_over));
            1:       it.bat_volt_mv = 16'($urandom_range(ctl_under, 0));
            default: it.bat_volt_mv = 16'($urandom);
        endcase
        it.charge_ma = clow ? 16'($urandom_range(ctl_cfg.min_current_ma, 0))
                            : 16'($urandom_range(16'hFFFF, ctl_cfg.min_current_ma));
        it.discharge_ma = dlow ? 16'($urandom_range(ctl_cfg.min_current_ma, 0))
                               : 16'($urandom_range(16'hFFFF, ctl_cfg.min_current_ma));
        it.has_command = 1'b0;
        it.cmd_addr    = 16'($urandom);
        it.cmd_value   = 16'($urandom);
        return it;
    endfunction

    function automatic item_t with_command(input item_t base);
        item_t it;
        it             = base;
        it.has_command = 1'b1;
        case ($urandom_range(6))
            0, 1:
            begin
                it.cmd_addr  = ADDR_CTRL;
                it.cmd_value = 16'($urandom_range(6));
            end
            2:
            begin
                it.cmd_addr  = ADDR_OVER;
                it.cmd_value = 16'($urandom_range(22000, 14000));
            end
            3:
            begin
                it.cmd_addr  = ADDR_UNDER;
                it.cmd_value = 16'($urandom_range(17000, 8000));
            end
            4:
            begin
                it.cmd_addr = ADDR_SELECT;
            end
            5:
            begin
                it.cmd_addr = ADDR_KIND;
                if ($urandom_range(1))
                    it.cmd_value = 16'($urandom_range(3));
            end
            default:
            begin
            end
        endcase
        return it;
    endfunction

    task automatic feed_item(input item_t it, input logic fixed, input res_t want);
        res_t model_out;
        int   gap;
        gap = gap_len();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.now_ms       <= it.now_ms;
        item_ch.bat_volt_mv  <= it.bat_volt_mv;
        item_ch.charge_ma    <= it.charge_ma;
        item_ch.discharge_ma <= it.discharge_ma;
        item_ch.has_command  <= it.has_command;
        item_ch.cmd_addr     <= it.cmd_addr;
        item_ch.cmd_value    <= it.cmd_value;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        model_out = advance_controller(it);
        due_outputs.push_back(fixed ? want : model_out);
        n_items++;
    endtask

    task automatic settle();
        item_ch.valid <= 1'b0;
        while (due_outputs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_settings(input cfg_t c);
        settle();
        wr_en    <= 1'b1;
        wr_index <= CFG_MIN_CURRENT;
        wr_data  <= {16'd0, c.min_current_ma};
        @(posedge clk);
        wr_index <= CFG_START_BLANK;
        wr_data  <= c.start_blank_ms;
        @(posedge clk);
        wr_index <= CFG_PROTECT_CONFIRM;
        wr_data  <= c.protect_confirm_ms;
        @(posedge clk);
        wr_index <= CFG_DONE_CONFIRM;
        wr_data  <= c.done_confirm_ms;
        @(posedge clk);
        wr_en    <= 1'b0;
        ctl_cfg = c;
    endtask

    // an optional stop, then one start followed by a run of measurements with occasional commands
    task automatic run_session(input int step_max);
        item_t it;
        int    len;
        int    vpick;
        int    r;
        bit    clow;
        bit    dlow;
        len   = $urandom_range(40, 4);
        calm  = ($urandom_range(3) == 0);
        vpick = $urandom_range(2);
        clow  = 1'($urandom_range(1));
        dlow  = 1'($urandom_range(1));
        if ($urandom_range(7) == 0)
            clock_ms = $urandom;
        if (ctl_mode != MODE_IDLE && $urandom_range(7) != 0)
        begin
            it             = meas_item(vpick, clow, dlow);
            it.has_command = 1'b1;
            it.cmd_addr    = ADDR_CTRL;
            it.cmd_value   = CTRL_STOP_BOTH;
            feed_item(it, 1'b0, '0);
        end
        it             = meas_item(vpick, clow, dlow);
        it.has_command = 1'b1;
        it.cmd_addr    = ADDR_CTRL;
        it.cmd_value   = $urandom_range(1) ? CTRL_START_CHG : CTRL_START_DIS;
        feed_item(it, 1'b0, '0);
        repeat (len)
        begin
            clock_ms = clock_ms + 32'($urandom_range(step_max));
            if ($urandom_range(4) == 0)
            begin
                vpick = $urandom_range(2);
                clow  = 1'($urandom_range(1));
                dlow  = 1'($urandom_range(1));
            end
            it = meas_item(vpick, clow, dlow);
            r  = $urandom_range(99);
            if (r < 6)
            begin
                it = with_command(it);
            end
            else if (r < 9)
            begin
                if ($urandom_range(1))
                    it.now_ms = $urandom;
                it.bat_volt_mv  = 16'($urandom);
                it.charge_ma    = 16'($urandom);
                it.discharge_ma = 16'($urandom);
                it.has_command  = 1'($urandom);
            end
            feed_item(it, 1'b0, '0);
        end
    endtask

    task automatic run_phase(input cfg_t c, input int step_max, input int budget);
        int target;
        write_settings(c);
        target = n_items + budget;
        while (n_items < target)
            run_session(step_max);
    endtask

    function automatic cfg_t rand_cfg();
        cfg_t c;
        c.min_current_ma     = 16'($urandom_range(2000));
        c.start_blank_ms     = $urandom_range(60);
        c.protect_confirm_ms = $urandom_range(80);
        c.done_confirm_ms    = $urandom_range(80);
        return c;
    endfunction

    task automatic check_beat();
        res_t got;
        res_t want;
        got.charge_on      = res_ch.charge_on;
        got.discharge_on   = res_ch.discharge_on;
        got.fan_on         = res_ch.fan_on;
        got.charge_led     = res_ch.charge_led;
        got.discharge_led  = res_ch.discharge_led;
        got.mode           = res_ch.mode;
        got.volt_select    = res_ch.volt_select;
        got.over_limit_mv  = res_ch.over_limit_mv;
        got.under_limit_mv = res_ch.under_limit_mv;
        got.battery_kind   = res_ch.battery_kind;
        if (due_outputs.size() == 0)
        begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("unexpected result beat: %s", fmt_res(got));
        end
        else
        begin
            want = due_outputs.pop_front();
            if (got !== want)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("result mismatch\n  exp %s\n  got %s", fmt_res(want), fmt_res(got));
            end
        end
    endtask

    // result side: check each beat, stall at random
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            take_ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
                check_beat();
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                take_ready <= 1'b0;
            end
            else
            begin
                stall_left = gap_len();
                take_ready <= (stall_left == 0);
            end
        end
    end

    always @(posedge clk)
    begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT)
        begin
            $display("FAIL battery_charge_discharge_controller");
            $finish;
        end
    end

    initial
    begin
        rst_n                = 1'b0;
        wr_en                = 1'b0;
        wr_index             = CFG_MIN_CURRENT;
        wr_data              = 32'd0;
        item_ch.valid        = 1'b0;
        item_ch.now_ms       = 32'd0;
        item_ch.bat_volt_mv  = 16'd0;
        item_ch.charge_ma    = 16'd0;
        item_ch.discharge_ma = 16'd0;
        item_ch.has_command  = 1'b0;
        item_ch.cmd_addr     = 16'd0;
        item_ch.cmd_value    = 16'd0;

        ctl_cfg    = '{RST_MIN_CURRENT, RST_START_BLANK, RST_PROTECT_CONFIRM, RST_DONE_CONFIRM};
        ctl_mode   = MODE_IDLE;
        ctl_over   = RST_OVER_LIMIT;
        ctl_under  = RST_UNDER_LIMIT;
        ctl_kind   = KIND_TYPE0;
        ctl_sel    = 2'd0;
        ctl_chg_t0 = 32'd0;
        ctl_dis_t0 = 32'd0;
        ctl_wait   = 4'd0;
        ctl_chg_on = 1'b0;
        ctl_dis_on = 1'b0;
        ctl_fan    = 1'b0;
        ctl_cled   = 1'b0;
        ctl_dled   = 1'b0;
        foreach (ctl_since[i])
            ctl_since[i] = 32'd0;

        // reset view, ignored command fields, limit and select extremes
        bringup_steps.push_back('{mk_item(32'd0, 16'd12000, 16'd1000, 16'd1000, 1'b0, 16'd0,
                                          16'd0), 1'b1,
                                  idle_view(2'd0, 16'd21000, 16'd16000, 8'd0)});
        bringup_steps.push_back('{mk_item(32'd0, 16'd12000, 16'd1000, 16'd1000, 1'b0, ADDR_KIND,
                                          16'd2), 1'b1,
                                  idle_view(2'd0, 16'd21000, 16'd16000, 8'd0)});
        bringup_steps.push_back('{mk_item(32'd0, 16'd12000, 16'd1000, 16'd1000, 1'b1, ADDR_OVER,
                                          16'hFFFF), 1'b1,
                                  idle_view(2'd0, 16'hFFFF, 16'd16000, 8'd0)});
        bringup_steps.push_back('{mk_item(32'd0, 16'd12000, 16'd1000, 16'd1000, 1'b1, ADDR_UNDER,
                                          16'd0), 1'b1,
                                  idle_view(2'd0, 16'hFFFF, 16'd0, 8'd0)});
        bringup_steps.push_back('{mk_item(32'd0, 16'd12000, 16'd1000, 16'd1000, 1'b1, 16'h0012,
                                          16'h1234), 1'b0, '0});
        bringup_steps.push_back('{mk_item(32'd0, 16'd12000, 16'd1000, 16'd1000, 1'b1, ADDR_SELECT,
                                          16'hFFFF), 1'b1,
                                  idle_view(2'd3, 16'hFFFF, 16'd0, 8'd0)});
        // unknown battery type is stored, table untouched
        bringup_steps.push_back('{mk_item(32'd0, 16'd12000, 16'd1000, 16'd1000, 1'b1, ADDR_KIND,
                                          16'h00FF), 1'b1,
                                  idle_view(2'd3, 16'hFFFF, 16'd0, 8'hFF)});
        bringup_steps.push_back('{mk_item(32'd1000, 16'd12000, 16'd1000, 16'd1000, 1'b1, ADDR_CTRL,
                                          CTRL_START_CHG), 1'b0, '0});
        // start and stop in the wrong state are dropped
        bringup_steps.push_back('{mk_item(32'd2000, 16'd12000, 16'd1000, 16'd1000, 1'b1, ADDR_CTRL,
                                          CTRL_START_DIS), 1'b0, '0});
        bringup_steps.push_back('{mk_item(32'd3000, 16'd12000, 16'd1000, 16'd1000, 1'b1, ADDR_CTRL,
                                          CTRL_STOP_DIS), 1'b0, '0});
        // over-voltage at full scale, confirmed after the protect time
        bringup_steps.push_back('{mk_item(32'd51000, 16'hFFFF, 16'hFFFF, 16'd0, 1'b0, 16'd0,
                                          16'd0), 1'b0, '0});
        bringup_steps.push_back('{mk_item(32'd101000, 16'hFFFF, 16'hFFFF, 16'd0, 1'b0, 16'd0,
                                          16'd0), 1'b0, '0});
        bringup_steps.push_back('{mk_item(32'd101001, 16'd12000, 16'd1000, 16'd1000, 1'b1,
                                          ADDR_KIND, 16'd1), 1'b1,
                                  idle_view(2'd3, 16'd17500, 16'd10000, 8'd1)});
        // charge done on low current, leds held for one beat afterwards
        bringup_steps.push_back('{mk_item(32'd200000, 16'd12000, 16'd1000, 16'd1000, 1'b1,
                                          ADDR_CTRL, CTRL_START_CHG), 1'b0, '0});
        bringup_steps.push_back('{mk_item(32'd250000, 16'd0, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0),
                                  1'b0, '0});
        bringup_steps.push_back('{mk_item(32'd280000, 16'd0, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0),
                                  1'b0, '0});
        bringup_steps.push_back('{mk_item(32'd280001, 16'd0, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0),
                                  1'b0, '0});
        // under-voltage cut-off across the timestamp wrap
        bringup_steps.push_back('{mk_item(32'hFFFF_FF00, 16'd12000, 16'd0, 16'd1000, 1'b1,
                                          ADDR_CTRL, CTRL_START_DIS), 1'b0, '0});
        bringup_steps.push_back('{mk_item(32'd49744, 16'd0, 16'd0, 16'hFFFF, 1'b0, 16'd0, 16'd0),
                                  1'b0, '0});
        bringup_steps.push_back('{mk_item(32'd99744, 16'd0, 16'd0, 16'hFFFF, 1'b0, 16'd0, 16'd0),
                                  1'b0, '0});
        bringup_steps.push_back('{mk_item(32'd100000, 16'd12000, 16'd0, 16'd1000, 1'b1, ADDR_CTRL,
                                          CTRL_START_DIS), 1'b0, '0});
        bringup_steps.push_back('{mk_item(32'd100001, 16'd12000, 16'd0, 16'd1000, 1'b1, ADDR_CTRL,
                                          CTRL_STOP_BOTH), 1'b0, '0});
        bringup_steps.push_back('{mk_item(32'd100002, 16'd12000, 16'd0, 16'd1000, 1'b1, ADDR_CTRL,
                                          CTRL_STOP_CHG), 1'b0, '0});
        bringup_steps.push_back('{mk_item(32'd100003, 16'd12000, 16'd0, 16'd1000, 1'b1, ADDR_CTRL,
                                          16'd6), 1'b0, '0});
        bringup_steps.push_back('{mk_item(32'd100004, 16'd12000, 16'd0, 16'd1000, 1'b1, 16'hFFFF,
                                          16'hFFFF), 1'b0, '0});
        // only the low byte of the type value is kept
        bringup_steps.push_back('{mk_item(32'd100005, 16'd12000, 16'd0, 16'd1000, 1'b1, ADDR_KIND,
                                          16'h0100), 1'b1,
                                  idle_view(2'd0, 16'd21500, 16'd12000, 8'd0)});

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (bringup_steps[i])
            feed_item(bringup_steps[i].stim, bringup_steps[i].fixed, bringup_steps[i].want);
        clock_ms = 32'd100005;

        // zero timing: a condition fires on its second sample
        run_phase('{16'd300, 32'd0, 32'd0, 32'd0}, 3, 90);
        run_phase(rand_cfg(), 12, 120);
        run_phase('{16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1000, 40);
        run_phase('{16'd0, 32'd20, 32'd30, 32'd30}, 8, 100);
        run_phase(rand_cfg(), 20, 80);
        run_phase('{RST_MIN_CURRENT, RST_START_BLANK, RST_PROTECT_CONFIRM, RST_DONE_CONFIRM},
                  20000, 70);

        settle();
        repeat (8) @(posedge clk);
        if (n_mismatch == 0 && due_outputs.size() == 0)
        begin
            $display("PASS battery_charge_discharge_controller");
        end
        else
        begin
            $display("FAIL battery_charge_discharge_controller");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/bcdc_pkg.sv
hw/rtl/bcdc_channels.sv
hw/rtl/bcdc_confirm.sv
hw/rtl/bcdc_core.sv
hw/rtl/battery_charge_discharge_controller.sv
dv/tb_battery_charge_discharge_controller.sv
